FILE: hdl/smacb_pkg.sv
`default_nettype none

package smacb_pkg;

    // Byte store geometry; the depth is a power of two so the address wrap is a truncation
    localparam int unsigned STORE_BYTES = 65536;
    localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

    // Command letters and reply characters
    localparam logic [7:0] CH_ACK     = 8'h61; // 'a'
    localparam logic [7:0] CH_GET     = 8'h67; // 'g'
    localparam logic [7:0] CH_SET     = 8'h73; // 's'
    localparam logic [7:0] CH_RDWORD  = 8'h72; // 'r'
    localparam logic [7:0] CH_WRWORD  = 8'h77; // 'w'
    localparam logic [7:0] CH_RDBLK   = 8'h52; // 'R'
    localparam logic [7:0] CH_WRBLK   = 8'h57; // 'W'
    localparam logic [7:0] CH_IDENT   = 8'h69; // 'i'
    localparam logic [7:0] CH_FLUSH3  = 8'h33; // '3'
    localparam logic [7:0] CH_FLUSH4  = 8'h34; // '4'
    localparam logic [7:0] CH_OK      = 8'h21; // '!'
    localparam logic [7:0] CH_UNKNOWN = 8'h3F; // '?'

    // Command parser phase
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ADDR = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    // Kind of reply being sent
    typedef enum logic [4:0] {
        RP_NONE  = 5'b00001,
        RP_ONE   = 5'b00010,
        RP_IDENT = 5'b00100,
        RP_WORD  = 5'b01000,
        RP_BLOCK = 5'b10000
    } reply_t;

    // What the second stage does with the checksum
    typedef enum logic [1:0] {
        SUM_KEEP,
        SUM_CLEAR,
        SUM_ADD_RX,
        SUM_ADD_MEM
    } sum_op_t;

    // What the second stage loads into the single-byte reply register
    typedef enum logic [1:0] {
        REP_KEEP,
        REP_CONST,
        REP_MEM,
        REP_SUM
    } rep_op_t;

    // Source of the transmitted byte
    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_CONST,
        OUT_MEM,
        OUT_REPLY,
        OUT_SUM
    } out_op_t;

    // Work handed from the parse stage to the data stage
    typedef struct packed {
        out_op_t    out_op;
        logic       last;
        sum_op_t    sum_op;
        rep_op_t    rep_op;
        logic [7:0] data;
    } tok_t;

    // Identification reply 00 FF 00 FF
    function automatic logic [7:0] ident_byte(input logic [1:0] idx);
        return idx[0] ? 8'hFF : 8'h00;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/serial_memory_access_command_bridge_top.sv
`default_nettype none

// Reply path: a taken transmit request goes to the token register, then to the output queue.
// Throughput: one transaction per cycle while the reply side drains; a two-entry output
//   queue decouples the sides, and the single-port byte store takes one access per item.
// Reset: control state clears at once; a clearing pass then writes zero to all 65536 store
//   bytes, one per cycle, and in_ready stays low until that pass is done.

module serial_memory_access_command_bridge_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cmd,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      tx_byte,
    output logic            reply_end
);

    localparam int unsigned AW = smacb_pkg::ADDR_W;

    // Parse-stage state
    smacb_pkg::phase_t  phase_reg,   phase_next;
    smacb_pkg::reply_t  rp_reg,      rp_next;
    logic [7:0]         letter_reg,  letter_next;
    logic [1:0]         cnt_reg,     cnt_next;
    logic [31:0]        operand_reg, operand_next;
    logic [AW-1:0]      addr_reg,    addr_next;
    logic [31:0]        rem_reg,     rem_next;

    // Data-stage state
    smacb_pkg::tok_t    tok_reg,     tok_next;
    logic [7:0]         sum_reg,     sum_next;
    logic [7:0]         reply_reg,   reply_next;
    logic [7:0]         rd_data_reg;

    // Clearing pass
    logic               clear_reg;
    logic [AW-1:0]      clr_addr_reg;

    // Output queue
    logic [7:0]         q_data_reg [2];
    logic               q_end_reg  [2];
    logic               head_reg;
    logic [1:0]         fifo_cnt_reg, fifo_cnt_next;

    // Store access from the parse stage
    logic               s1_we, s1_re;
    logic [AW-1:0]      s1_addr;
    logic [31:0]        op_full;
    logic [AW-1:0]      op_addr;

    logic               in_acc;
    logic               s2_push;
    logic               out_pop;
    logic [7:0]         s2_byte;
    logic               wslot;

    logic [7:0]         store_mem [smacb_pkg::STORE_BYTES];

    assign in_acc  = in_valid & in_ready;
    assign out_pop = out_valid & out_ready;
    assign s2_push = (tok_reg.out_op != smacb_pkg::OUT_NONE);

    // Queue occupancy after this edge decides whether one more item fits
    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg + {1'b0, s2_push} - {1'b0, out_pop};
    end

    assign in_ready = !clear_reg && (fifo_cnt_next <= 2'd1);

    // Operand with the received byte placed in its lane
    always_comb
    begin
        op_full = operand_reg;
        op_full[8*cnt_reg +: 8] = rx_byte;
    end
    assign op_addr = op_full[AW-1:0];

    // Parse stage: command decoding, store address and work for the data stage
    always_comb
    begin
        phase_next   = phase_reg;
        rp_next      = rp_reg;
        letter_next  = letter_reg;
        cnt_next     = cnt_reg;
        operand_next = operand_reg;
        addr_next    = addr_reg;
        rem_next     = rem_reg;
        tok_next     = '0;
        s1_we        = 1'b0;
        s1_re        = 1'b0;
        s1_addr      = addr_reg;

        if (in_acc)
        begin
            if (!cmd)
            begin
                // received bytes are dropped while a reply is pending
                if (rp_reg == smacb_pkg::RP_NONE)
                begin
                    unique case (phase_reg)
                        smacb_pkg::PH_IDLE:
                        begin
                            letter_next = rx_byte;
                            cnt_next    = 2'd0;
                            unique case (rx_byte)
                                smacb_pkg::CH_ACK:
                                begin
                                    tok_next.rep_op = smacb_pkg::REP_CONST;
                                    tok_next.data   = smacb_pkg::CH_OK;
                                    rp_next         = smacb_pkg::RP_ONE;
                                end
                                smacb_pkg::CH_GET, smacb_pkg::CH_SET,
                                smacb_pkg::CH_RDWORD, smacb_pkg::CH_WRWORD,
                                smacb_pkg::CH_RDBLK, smacb_pkg::CH_WRBLK:
                                begin
                                    phase_next = smacb_pkg::PH_ADDR;
                                end
                                smacb_pkg::CH_IDENT:
                                begin
                                    rp_next = smacb_pkg::RP_IDENT;
                                end
                                smacb_pkg::CH_FLUSH3, smacb_pkg::CH_FLUSH4:
                                begin
                                end
                                default:
                                begin
                                    tok_next.rep_op = smacb_pkg::REP_CONST;
                                    tok_next.data   = smacb_pkg::CH_UNKNOWN;
                                    rp_next         = smacb_pkg::RP_ONE;
                                end
                            endcase
                        end
                        smacb_pkg::PH_ADDR, smacb_pkg::PH_LEN:
                        begin
                            operand_next = op_full;
                            if (cnt_reg == 2'd3)
                            begin
                                cnt_next = 2'd0;
                                if (phase_reg == smacb_pkg::PH_ADDR)
                                begin
                                    addr_next = op_addr;
                                    unique case (letter_reg)
                                        smacb_pkg::CH_GET:
                                        begin
                                            s1_re           = 1'b1;
                                            s1_addr         = op_addr;
                                            tok_next.rep_op = smacb_pkg::REP_MEM;
                                            rp_next         = smacb_pkg::RP_ONE;
                                            phase_next      = smacb_pkg::PH_IDLE;
                                        end
                                        smacb_pkg::CH_SET:
                                        begin
                                            phase_next = smacb_pkg::PH_DATA;
                                        end
                                        smacb_pkg::CH_RDWORD:
                                        begin
                                            addr_next  = {op_addr[AW-1:2], 2'b00};
                                            rp_next    = smacb_pkg::RP_WORD;
                                            phase_next = smacb_pkg::PH_IDLE;
                                        end
                                        smacb_pkg::CH_WRWORD:
                                        begin
                                            addr_next  = {op_addr[AW-1:2], 2'b00};
                                            phase_next = smacb_pkg::PH_DATA;
                                        end
                                        default:
                                        begin
                                            phase_next = smacb_pkg::PH_LEN;
                                        end
                                    endcase
                                end
                                else
                                begin
                                    rem_next        = op_full;
                                    tok_next.sum_op = smacb_pkg::SUM_CLEAR;
                                    if (letter_reg == smacb_pkg::CH_RDBLK)
                                    begin
                                        rp_next    = smacb_pkg::RP_BLOCK;
                                        phase_next = smacb_pkg::PH_IDLE;
                                    end
                                    else if (op_full == 32'd0)
                                    begin
                                        tok_next.rep_op = smacb_pkg::REP_CONST;
                                        tok_next.data   = 8'h00;
                                        rp_next         = smacb_pkg::RP_ONE;
                                        phase_next      = smacb_pkg::PH_IDLE;
                                    end
                                    else
                                    begin
                                        phase_next = smacb_pkg::PH_DATA;
                                    end
                                end
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 2'd1;
                            end
                        end
                        smacb_pkg::PH_DATA:
                        begin
                            s1_we = 1'b1;
                            if (letter_reg == smacb_pkg::CH_SET)
                            begin
                                phase_next = smacb_pkg::PH_IDLE;
                            end
                            else if (letter_reg == smacb_pkg::CH_WRWORD)
                            begin
                                s1_addr = addr_reg + AW'(cnt_reg);
                                if (cnt_reg == 2'd3)
                                begin
                                    cnt_next   = 2'd0;
                                    phase_next = smacb_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    cnt_next = cnt_reg + 2'd1;
                                end
                            end
                            else
                            begin
                                // block write: checksum follows the last byte
                                tok_next.sum_op = smacb_pkg::SUM_ADD_RX;
                                tok_next.data   = rx_byte;
                                addr_next       = addr_reg + AW'(1);
                                rem_next        = rem_reg - 32'd1;
                                if (rem_reg == 32'd1)
                                begin
                                    tok_next.rep_op = smacb_pkg::REP_SUM;
                                    rp_next         = smacb_pkg::RP_ONE;
                                    phase_next      = smacb_pkg::PH_IDLE;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = smacb_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            else
            begin
                // transmit request
                unique case (rp_reg)
                    smacb_pkg::RP_ONE:
                    begin
                        tok_next.out_op = smacb_pkg::OUT_REPLY;
                        tok_next.last   = 1'b1;
                        rp_next         = smacb_pkg::RP_NONE;
                    end
                    smacb_pkg::RP_IDENT, smacb_pkg::RP_WORD:
                    begin
                        if (rp_reg == smacb_pkg::RP_IDENT)
                        begin
                            tok_next.out_op = smacb_pkg::OUT_CONST;
                            tok_next.data   = smacb_pkg::ident_byte(cnt_reg);
                        end
                        else
                        begin
                            tok_next.out_op = smacb_pkg::OUT_MEM;
                            s1_re           = 1'b1;
                            s1_addr         = addr_reg + AW'(cnt_reg);
                        end
                        if (cnt_reg == 2'd3)
                        begin
                            tok_next.last = 1'b1;
                            cnt_next      = 2'd0;
                            rp_next       = smacb_pkg::RP_NONE;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 2'd1;
                        end
                    end
                    smacb_pkg::RP_BLOCK:
                    begin
                        if (rem_reg != 32'd0)
                        begin
                            s1_re           = 1'b1;
                            tok_next.out_op = smacb_pkg::OUT_MEM;
                            tok_next.sum_op = smacb_pkg::SUM_ADD_MEM;
                            addr_next       = addr_reg + AW'(1);
                            rem_next        = rem_reg - 32'd1;
                        end
                        else
                        begin
                            tok_next.out_op = smacb_pkg::OUT_SUM;
                            tok_next.last   = 1'b1;
                            rp_next         = smacb_pkg::RP_NONE;
                        end
                    end
                    default:
                    begin
                        rp_next = smacb_pkg::RP_NONE;
                    end
                endcase
            end
        end
    end

    // Data stage: checksum, single-byte reply and the byte to send
    always_comb
    begin
        sum_next   = sum_reg;
        reply_next = reply_reg;
        s2_byte    = 8'h00;

        unique case (tok_reg.sum_op)
            smacb_pkg::SUM_CLEAR:   sum_next = 8'h00;
            smacb_pkg::SUM_ADD_RX:  sum_next = sum_reg + tok_reg.data;
            smacb_pkg::SUM_ADD_MEM: sum_next = sum_reg + rd_data_reg;
            default:                sum_next = sum_reg;
        endcase

        unique case (tok_reg.rep_op)
            smacb_pkg::REP_CONST: reply_next = tok_reg.data;
            smacb_pkg::REP_MEM:   reply_next = rd_data_reg;
            smacb_pkg::REP_SUM:   reply_next = sum_next;
            default:              reply_next = reply_reg;
        endcase

        unique case (tok_reg.out_op)
            smacb_pkg::OUT_CONST: s2_byte = tok_reg.data;
            smacb_pkg::OUT_MEM:   s2_byte = rd_data_reg;
            smacb_pkg::OUT_REPLY: s2_byte = reply_reg;
            smacb_pkg::OUT_SUM:   s2_byte = sum_reg;
            default:              s2_byte = 8'h00;
        endcase
    end

    // Control and pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= smacb_pkg::PH_IDLE;
            rp_reg       <= smacb_pkg::RP_NONE;
            letter_reg   <= 8'h00;
            cnt_reg      <= 2'd0;
            operand_reg  <= 32'd0;
            addr_reg     <= '0;
            rem_reg      <= 32'd0;
            tok_reg      <= '0;
            sum_reg      <= 8'h00;
            reply_reg    <= 8'h00;
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
            head_reg     <= 1'b0;
            fifo_cnt_reg <= 2'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            rp_reg       <= rp_next;
            letter_reg   <= letter_next;
            cnt_reg      <= cnt_next;
            operand_reg  <= operand_next;
            addr_reg     <= addr_next;
            rem_reg      <= rem_next;
            tok_reg      <= tok_next;
            sum_reg      <= sum_next;
            reply_reg    <= reply_next;
            fifo_cnt_reg <= fifo_cnt_next;
            if (out_pop)
            begin
                head_reg <= ~head_reg;
            end
            if (clear_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    clear_reg <= 1'b0;
                end
            end
        end
    end

    // Output queue slots
    assign wslot = head_reg ^ fifo_cnt_reg[0];

    always_ff @(posedge clk)
    begin
        if (s2_push)
        begin
            q_data_reg[wslot] <= s2_byte;
            q_end_reg[wslot]  <= tok_reg.last;
        end
    end

    assign out_valid = (fifo_cnt_reg != 2'd0);
    assign tx_byte   = q_data_reg[head_reg];
    assign reply_end = q_end_reg[head_reg];

    // Byte store: one access a cycle, clearing pass first
    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            store_mem[clr_addr_reg] <= 8'h00;
        end
        else if (s1_we)
        begin
            store_mem[s1_addr] <= rx_byte;
        end
        if (s1_re)
        begin
            rd_data_reg <= store_mem[s1_addr];
        end
    end

    // The output queue never takes a byte it has no room for
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_cnt_reg == 2'd2 && s2_push && !out_pop))
        else $error("output queue overflow");

    // Nothing reaches the data stage during the clearing pass
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> (tok_reg.out_op == smacb_pkg::OUT_NONE && !s1_we))
        else $error("activity during clearing pass");

    // An ack taken while idle leaves a one-byte reply pending; the byte then reaches reply_reg
    a_ack_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !cmd && rp_reg == smacb_pkg::RP_NONE && phase_reg == smacb_pkg::PH_IDLE
         && rx_byte == smacb_pkg::CH_ACK)
        |=> (rp_reg == smacb_pkg::RP_ONE) ##1 (reply_reg == smacb_pkg::CH_OK))
        else $error("ack did not queue a reply");

endmodule

`default_nettype wire

FILE: sim/smacb_reply_checker_pkg.sv
package smacb_reply_checker_pkg;

    import smacb_pkg::*;

    // Letters the block does not support; they must answer as unknown
    localparam logic [7:0] CH_CALL = 8'h63; // 'c'
    localparam logic [7:0] CH_DRAM = 8'h64; // 'd'

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
    } reply_byte_t;

    // Mirror of the command parser and byte store, plus the queue of reply bytes still owed
    class reply_checker;

        phase_t      phase;
        logic [7:0]  letter;
        logic [1:0]  nbytes;
        logic [31:0] shifter;
        logic [31:0] addr;
        logic [31:0] remain;
        logic [7:0]  sum;
        reply_t      pend;
        logic [7:0]  mem [STORE_BYTES];
        logic [7:0]  id_seq [4];
        reply_byte_t due_bytes [$];
        int          errors;

        function new();
            phase   = PH_IDLE;
            letter  = 8'h00;
            nbytes  = 2'd0;
            shifter = 32'h0;
            addr    = 32'h0;
            remain  = 32'h0;
            sum     = 8'h00;
            pend    = RP_NONE;
            errors  = 0;
            id_seq  = '{8'h00, 8'hFF, 8'h00, 8'hFF};
            foreach (mem[i])
                mem[i] = 8'h00;
        endfunction

        function logic [31:0] wrap(input logic [31:0] a);
            return a % STORE_BYTES;
        endfunction

        function void queue_single(input logic [7:0] v);
            shifter = {24'h0, v};
            pend    = RP_ONE;
            phase   = PH_IDLE;
        endfunction

        // Command letter while idle
        function void on_letter(input logic [7:0] b);
            letter  = b;
            nbytes  = 2'd0;
            shifter = 32'h0;
            case (b)
                CH_ACK:
                    queue_single(CH_OK);
                CH_GET, CH_SET, CH_RDWORD, CH_WRWORD, CH_RDBLK, CH_WRBLK:
                    phase = PH_ADDR;
                CH_IDENT:
                    pend = RP_IDENT;
                CH_FLUSH3, CH_FLUSH4:
                    ;
                default:
                    queue_single(CH_UNKNOWN);
            endcase
        endfunction

        // Fourth address byte taken
        function void on_address();
            addr    = wrap(shifter);
            nbytes  = 2'd0;
            shifter = 32'h0;
            case (letter)
                CH_GET:
                    queue_single(mem[addr]);
                CH_SET:
                    phase = PH_DATA;
                CH_RDWORD:
                begin
                    addr[1:0] = 2'b00;
                    pend      = RP_WORD;
                    phase     = PH_IDLE;
                end
                CH_WRWORD:
                begin
                    addr[1:0] = 2'b00;
                    phase     = PH_DATA;
                end
                default:
                    phase = PH_LEN;
            endcase
        endfunction

        // Fourth length byte taken
        function void on_length();
            remain  = shifter;
            sum     = 8'h00;
            nbytes  = 2'd0;
            shifter = 32'h0;
            if (letter == CH_RDBLK)
            begin
                pend  = RP_BLOCK;
                phase = PH_IDLE;
            end
            else if (remain == 32'h0)
                queue_single(8'h00);
            else
                phase = PH_DATA;
        endfunction

        function void on_data(input logic [7:0] b);
            if (letter == CH_SET)
            begin
                mem[addr] = b;
                phase     = PH_IDLE;
            end
            else if (letter == CH_WRWORD)
            begin
                mem[wrap(addr + nbytes)] = b;
                if (nbytes == 2'd3)
                begin
                    nbytes = 2'd0;
                    phase  = PH_IDLE;
                end
                else
                    nbytes++;
            end
            else
            begin
                mem[addr] = b;
                sum       = sum + b;
                addr      = wrap(addr + 32'd1);
                remain    = remain - 32'd1;
                if (remain == 32'h0)
                    queue_single(sum);
            end
        endfunction

        // One accepted input transaction; owed reply bytes are queued
        function void take_transaction(input logic c, input logic [7:0] b);
            reply_byte_t r;
            logic        hit;
            r.tx   = 8'h00;
            r.last = 1'b0;
            hit    = 1'b1;
            if (!c)
            begin
                // received bytes are dropped while a reply is owed
                if (pend != RP_NONE)
                    return;
                case (phase)
                    PH_IDLE:
                        on_letter(b);
                    PH_ADDR, PH_LEN:
                    begin
                        shifter = shifter | ({24'h0, b} << (8 * nbytes));
                        if (nbytes == 2'd3)
                        begin
                            if (phase == PH_ADDR)
                                on_address();
                            else
                                on_length();
                        end
                        else
                            nbytes++;
                    end
                    PH_DATA:
                        on_data(b);
                    default:
                        phase = PH_IDLE;
                endcase
                return;
            end
            // transmit pull
            case (pend)
                RP_ONE:
                begin
                    r.tx   = shifter[7:0];
                    r.last = 1'b1;
                end
                RP_IDENT, RP_WORD:
                begin
                    if (pend == RP_IDENT)
                        r.tx = id_seq[nbytes];
                    else
                        r.tx = mem[wrap(addr + nbytes)];
                    if (nbytes == 2'd3)
                    begin
                        r.last = 1'b1;
                        nbytes = 2'd0;
                    end
                    else
                        nbytes++;
                end
                RP_BLOCK:
                begin
                    if (remain != 32'h0)
                    begin
                        r.tx   = mem[addr];
                        sum    = sum + r.tx;
                        addr   = wrap(addr + 32'd1);
                        remain = remain - 32'd1;
                    end
                    else
                    begin
                        r.tx   = sum;
                        r.last = 1'b1;
                    end
                end
                default:
                begin
                    pend = RP_NONE;
                    hit  = 1'b0;
                end
            endcase
            if (hit)
            begin
                if (r.last)
                    pend = RP_NONE;
                due_bytes.push_back(r);
            end
        endfunction

        // One accepted reply transaction against the oldest owed byte
        function void check_reply(input logic [7:0] tx, input logic last);
            reply_byte_t want;
            if (due_bytes.size() == 0)
            begin
                $display("%0t: reply byte with none owed: expected none, got tx_byte %02h reply_end %0b",
                         $time, tx, last);
                errors++;
                return;
            end
            want = due_bytes.pop_front();
            if (tx !== want.tx)
            begin
                $display("%0t: tx_byte mismatch: expected %02h, got %02h", $time, want.tx, tx);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: reply_end mismatch: expected %0b, got %0b", $time, want.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage

FILE: sim/serial_memory_access_command_bridge_top_tb.sv
module serial_memory_access_command_bridge_top_tb;

    import smacb_pkg::*;
    import smacb_reply_checker_pkg::*;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       cmd       = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] tx_byte;
    logic       reply_end;

    reply_checker chk = new();
    int           n_items = 0;
    logic         calm = 1'b0;

    serial_memory_access_command_bridge_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .reply_end (reply_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit: covers the store clearing pass and the slowest legal traffic many times over
    initial
    begin
        #7200000;
        $display("FAIL serial_memory_access_command_bridge_top");
        $finish;
    end

    // Reply side: random stalls, check every accepted transaction
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            chk.check_reply(tx_byte, reply_end);
        out_ready <= rst_n && (calm || ($urandom_range(0, 99) >= 12));
    end

    // One input transaction, held until accepted, then an occasional gap
    task automatic send_item(input logic c, input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        cmd      <= c;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        chk.take_transaction(c, b);
        n_items++;
        calm = (n_items >= 500 && n_items < 800);
        if (!calm && $urandom_range(0, 99) < 12)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(1'b0, b);
    endtask

    task automatic send_pull();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_u32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            send_rx(v[8 * i +: 8]);
    endtask

    function automatic logic [7:0] any_letter();
        case ($urandom_range(0, 5))
            0: return CH_GET;
            1: return CH_SET;
            2: return CH_RDWORD;
            3: return CH_WRWORD;
            4: return CH_RDBLK;
            default: return CH_WRBLK;
        endcase
    endfunction

    // Mostly a small window so reads find earlier writes; some near the wrap, some anywhere
    function automatic logic [31:0] pick_address();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return ($urandom & 32'hFFFF_0000) | $urandom_range(0, 63);
        else if (p < 75)
            return ($urandom & 32'hFFFF_0000) | (32'h0000_FFC0 + $urandom_range(0, 63));
        else
            return $urandom;
    endfunction

    function automatic logic [31:0] pick_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(0, 8);
        else if (p < 95)
            return $urandom_range(9, 48);
        else
            return $urandom_range(49, 300);
    endfunction

    // Bring the parser back to idle and drain any owed reply, with noise on the way
    task automatic settle();
        while (chk.phase != PH_IDLE || chk.pend != RP_NONE)
        begin
            if (chk.pend != RP_NONE)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_rx(8'($urandom_range(0, 255)));
                else
                    send_pull();
            end
            else if (chk.phase == PH_LEN)
                send_rx(8'h00);
            else if ($urandom_range(0, 3) == 0)
                send_rx(any_letter());
            else
                send_rx(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic cmd_addr(input logic [7:0] l, input logic [31:0] a);
        send_rx(l);
        send_u32(a);
    endtask

    // One random command, well formed in most cases, then drained
    task automatic random_command();
        logic [7:0]  l;
        logic [31:0] a;
        logic [31:0] len;
        int          p;
        int          n;
        p = $urandom_range(0, 99);
        if (p < 14)
            l = CH_GET;
        else if (p < 26)
            l = CH_SET;
        else if (p < 38)
            l = CH_RDWORD;
        else if (p < 50)
            l = CH_WRWORD;
        else if (p < 62)
            l = CH_RDBLK;
        else if (p < 74)
            l = CH_WRBLK;
        else if (p < 79)
            l = CH_ACK;
        else if (p < 84)
            l = CH_IDENT;
        else if (p < 87)
            l = CH_FLUSH3;
        else if (p < 90)
            l = CH_FLUSH4;
        else
            l = 8'($urandom_range(0, 255));
        a   = pick_address();
        len = pick_length();
        send_rx(l);
        if (chk.phase == PH_ADDR && $urandom_range(0, 99) < 8)
        begin
            // broken: address cut short, the next bytes land as operands
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                send_rx(a[8 * i +: 8]);
        end
        else if (chk.phase == PH_ADDR)
        begin
            send_u32(a);
            if (chk.phase == PH_LEN)
                send_u32(len);
            if (chk.phase == PH_DATA)
            begin
                if (l == CH_SET)
                    n = 1;
                else if (l == CH_WRWORD)
                    n = 4;
                else
                    n = int'(len);
                if (l == CH_WRBLK && $urandom_range(0, 99) < 5)
                    n = $urandom_range(0, n);
                repeat (n) send_rx(8'($urandom_range(0, 255)));
            end
        end
        settle();
    endtask

    // Stimulus
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every command, unsupported letters, address wrap, zero-length blocks
        send_pull();
        send_rx(CH_ACK);    settle();
        send_rx(CH_IDENT);  settle();
        send_rx(CH_FLUSH3); settle();
        send_rx(CH_FLUSH4); settle();
        send_rx(CH_CALL);   settle();
        send_rx(CH_DRAM);   settle();
        cmd_addr(CH_SET, 32'h0001_FFFF); send_rx(8'hFF); settle();
        cmd_addr(CH_GET, 32'hFFFF_FFFF); settle();
        cmd_addr(CH_GET, 32'h0000_0000); settle();
        cmd_addr(CH_WRWORD, 32'h0000_0003);
        send_u32(32'h0180_FF00); settle();
        cmd_addr(CH_RDWORD, 32'hFFFF_0001); settle();
        cmd_addr(CH_RDWORD, 32'hFFFF_FFFE); settle();
        cmd_addr(CH_RDBLK, 32'h0000_0010); send_u32(32'h0); settle();
        cmd_addr(CH_WRBLK, 32'h0000_0010); send_u32(32'h0); settle();
        cmd_addr(CH_WRBLK, 32'h0000_FFFE); send_u32(32'd4);
        send_u32(32'h7F80_FF01); settle();
        cmd_addr(CH_RDBLK, 32'h0000_FFFE); send_u32(32'd4); settle();

        // Random traffic with the odd stray pull
        while (n_items < 1120)
        begin
            if ($urandom_range(0, 99) < 6)
                send_pull();
            random_command();
        end

        // Block write with a near-full 32-bit length, left unfinished
        cmd_addr(CH_WRBLK, pick_address());
        send_u32(32'hFFFF_FF00 | $urandom_range(0, 255));
        repeat (160)
        begin
            if ($urandom_range(0, 9) == 0)
                send_pull();
            send_rx(8'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;

        while (chk.due_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (chk.errors == 0)
            $display("PASS serial_memory_access_command_bridge_top");
        else
            $display("FAIL serial_memory_access_command_bridge_top");
        $finish;
    end

endmodule

FILE: serial_memory_access_command_bridge_top.f
hdl/smacb_pkg.sv
hdl/serial_memory_access_command_bridge_top.sv
sim/smacb_reply_checker_pkg.sv
sim/serial_memory_access_command_bridge_top_tb.sv
